>>> src/unix_seconds_to_calendar_macros.svh
// Assertion helpers shared by the calendar converter.
// Every property samples on clk and is held off while rst is high.
`ifndef UNIX_SECONDS_TO_CALENDAR_MACROS_SVH
`define UNIX_SECONDS_TO_CALENDAR_MACROS_SVH

// ante implies cons in the same cycle
`define UCAL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cond holds at every edge out of reset
`define UCAL_ASSERT_ALWAYS(lbl, cond, msg) \
  `UCAL_ASSERT_IMPL(lbl, 1'b1, cond, msg)

`endif

>>> src/ucal_pkg.sv
package ucal_pkg;

  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY = 10;

  // Seconds to days: drop the low 7 bits (86400 = 128 * 675), then divide
  // the rest by 675 with a reciprocal multiply.
  localparam int          SEC_SHIFT  = 7;
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam int          DAY_SHIFT  = 35;
  localparam logic [9:0]  DAY_CHUNKS = 10'd675;

  localparam logic [17:0] HOUR_RECIP    = 18'd149131;
  localparam int          HOUR_SHIFT    = 29;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  localparam logic [12:0] MIN_RECIP    = 13'd4370;
  localparam int          MIN_SHIFT    = 18;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  // Dates are counted from 1968-01-01 in plain four-year cycles. The missing
  // leap day of 2100 is covered by adding one day from 2100-03-01 on.
  localparam logic [16:0] CYCLE_RECIP  = 17'd91868;
  localparam int          CYCLE_SHIFT  = 27;
  localparam logic [10:0] CYCLE_DAYS   = 11'd1461;
  localparam logic [15:0] BASE_OFFSET  = 16'd731;
  localparam logic [15:0] LEAP_FIX_DAY = 16'd47541;
  localparam logic [11:0] BASE_YEAR    = 12'd1968;

  localparam logic [16:0] WEEK_RECIP    = 17'd74899;
  localparam int          WEEK_SHIFT    = 19;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;

  // Day of the cycle at which each year of a cycle starts.
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  localparam logic [3:0] LAST_MONTH = 4'd11;

  typedef struct packed {
    logic [15:0] days;
    logic [16:0] sod;
  } ucal_split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } ucal_tod_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } ucal_date_t;

  // First day of year of month idx (0 is January); leap shifts March on.
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'd0, (leap && (idx >= 4'd2))};
  endfunction

endpackage

>>> src/ucal_split.sv
module ucal_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          secs,
  output logic                 out_valid,
  output ucal_pkg::ucal_split_t out
);
  import ucal_pkg::*;

  logic [2:0]  valid;
  logic [50:0] day_prod;
  logic [24:0] q1_a, q1_b;
  logic [6:0]  r1_a, r1_b;
  logic [15:0] days_b;
  logic [24:0] chunk_prod;
  logic [24:0] rem_chunks;

  assign rem_chunks = q1_b - chunk_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: reciprocal multiply for the day count
    day_prod   <= 51'(secs[31:SEC_SHIFT]) * 51'(DAY_RECIP);
    q1_a       <= secs[31:SEC_SHIFT];
    r1_a       <= secs[SEC_SHIFT-1:0];
    // stage 2: days back to 128-second chunks
    days_b     <= day_prod[DAY_SHIFT+15:DAY_SHIFT];
    chunk_prod <= 25'(day_prod[DAY_SHIFT+15:DAY_SHIFT]) * 25'(DAY_CHUNKS);
    q1_b       <= q1_a;
    r1_b       <= r1_a;
    // stage 3: second of day
    out.days   <= days_b;
    out.sod    <= {rem_chunks[9:0], r1_b};
  end

  assign out_valid = valid[2];

endmodule

>>> src/ucal_tod.sv
module ucal_tod (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [16:0]         sod,
  output logic                out_valid,
  output ucal_pkg::ucal_tod_t out
);
  import ucal_pkg::*;

  logic [5:0]  valid;
  logic [34:0] hour_prod;
  logic [16:0] sod_a, sod_b;
  logic [4:0]  hour_b, hour_c, hour_d, hour_e;
  logic [16:0] hour_secs;
  logic [11:0] rem_c, rem_d, rem_e;
  logic [24:0] min_prod;
  logic [5:0]  min_e;
  logic [11:0] min_secs;
  logic [16:0] rem_full;
  logic [11:0] sec_full;

  assign rem_full = sod_b - hour_secs;
  assign sec_full = rem_e - min_secs;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    hour_prod  <= 35'(sod) * 35'(HOUR_RECIP);
    sod_a      <= sod;

    hour_b     <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
    hour_secs  <= 17'(hour_prod[HOUR_SHIFT+4:HOUR_SHIFT]) * 17'(SECS_PER_HOUR);
    sod_b      <= sod_a;

    rem_c      <= rem_full[11:0];
    hour_c     <= hour_b;

    min_prod   <= 25'(rem_c) * 25'(MIN_RECIP);
    rem_d      <= rem_c;
    hour_d     <= hour_c;

    min_e      <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
    min_secs   <= 12'(min_prod[MIN_SHIFT+5:MIN_SHIFT]) * 12'(SECS_PER_MIN);
    rem_e      <= rem_d;
    hour_e     <= hour_d;

    out.hour   <= hour_e;
    out.minute <= min_e;
    out.second <= sec_full[5:0];
  end

  assign out_valid = valid[5];

endmodule

>>> src/ucal_date.sv
module ucal_date (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [15:0]          days,
  output logic                 out_valid,
  output ucal_pkg::ucal_date_t out
);
  import ucal_pkg::*;

  logic [6:0]  valid;
  // stage 1
  logic [15:0] dp_a, wk_a;
  // stage 2
  logic [32:0] cyc_prod, wk_prod;
  logic [15:0] dp_b, wk_b;
  // stage 3
  logic [5:0]  cyc_c;
  logic [15:0] cyc_days_c, wk_mul_c, dp_c, wk_c;
  // stage 4
  logic [5:0]  cyc_d;
  logic [10:0] doc_d;
  logic [2:0]  wd_d;
  // stage 5
  logic [8:0]  doy_e;
  logic        leap_e;
  logic [11:0] year_e;
  logic [2:0]  wd_e;
  // stage 6
  logic [3:0]  idx_f;
  logic [8:0]  doy_f;
  logic        leap_f;
  logic [11:0] year_f;
  logic [2:0]  wd_f;

  logic [15:0] doc_full, wd_full;
  logic [1:0]  yoff;
  logic [10:0] doy_full;
  logic [3:0]  idx_next;
  logic [8:0]  dom_full;

  assign doc_full = dp_c - cyc_days_c;
  assign wd_full  = wk_c - wk_mul_c;

  // year within the four-year cycle
  always_comb begin
    priority if (doc_d < YEAR1_START) begin
      yoff     = 2'd0;
      doy_full = doc_d;
    end else if (doc_d < YEAR2_START) begin
      yoff     = 2'd1;
      doy_full = doc_d - YEAR1_START;
    end else if (doc_d < YEAR3_START) begin
      yoff     = 2'd2;
      doy_full = doc_d - YEAR2_START;
    end else begin
      yoff     = 2'd3;
      doy_full = doc_d - YEAR3_START;
    end
  end

  // month: last start not beyond the day of year
  always_comb begin
    idx_next = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (doy_e >= month_start(4'(k), leap_e)) begin
        idx_next = 4'(k);
      end
    end
  end

  assign dom_full = doy_f - month_start(idx_f, leap_f) + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    dp_a       <= days + ((days >= LEAP_FIX_DAY) ? (BASE_OFFSET + 16'd1) : BASE_OFFSET);
    wk_a       <= days + EPOCH_WEEKDAY;

    cyc_prod   <= 33'(dp_a) * 33'(CYCLE_RECIP);
    wk_prod    <= 33'(wk_a) * 33'(WEEK_RECIP);
    dp_b       <= dp_a;
    wk_b       <= wk_a;

    cyc_c      <= cyc_prod[CYCLE_SHIFT+5:CYCLE_SHIFT];
    cyc_days_c <= 16'(cyc_prod[CYCLE_SHIFT+5:CYCLE_SHIFT]) * 16'(CYCLE_DAYS);
    wk_mul_c   <= 16'(wk_prod[WEEK_SHIFT+12:WEEK_SHIFT]) * 16'(DAYS_PER_WEEK);
    dp_c       <= dp_b;
    wk_c       <= wk_b;

    cyc_d      <= cyc_c;
    doc_d      <= doc_full[10:0];
    wd_d       <= wd_full[2:0];

    doy_e      <= doy_full[8:0];
    leap_e     <= (yoff == 2'd0);
    year_e     <= BASE_YEAR + {4'd0, cyc_d, 2'b00} + {10'd0, yoff};
    wd_e       <= wd_d;

    idx_f      <= idx_next;
    doy_f      <= doy_e;
    leap_f     <= leap_e;
    year_f     <= year_e;
    wd_f       <= wd_e;

    out.weekday <= wd_f;
    out.day     <= dom_full[4:0];
    out.month   <= idx_f + 4'd1;
    out.year    <= year_f;
  end

  assign out_valid = valid[6];

endmodule

>>> src/unix_seconds_to_calendar.sv
// Channel  | Signals                                   | Handshake
// ---------+-------------------------------------------+----------------------------------
// request  | epoch_seconds[31:0]                       | taken when start && !busy
// result   | second_of_minute, minute_of_hour,         | done strobe, one cycle, no stall
//          | hour_of_day, weekday, day_of_month,       |
//          | month_number, full_year                   |
//
// A request runs through the split pipe (3) and then the date pipe (7); one
// request may enter every cycle while busy is low, and results leave in
// request order.
// rst is synchronous and clears every valid bit; busy follows rst, so no
// request is taken while reset is held. Results cannot be held off, so the
// pipe never stalls.
`include "unix_seconds_to_calendar_macros.svh"

module unix_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [2:0]  weekday,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_number,
  output logic [11:0] full_year
);
  import ucal_pkg::*;

  logic        accept;
  logic        split_valid;
  ucal_split_t split;
  logic        tod_valid_raw;
  ucal_tod_t   tod_raw;
  logic        tod_valid;
  ucal_tod_t   tod;
  logic        date_valid;
  ucal_date_t  date;

  // Take no request while reset holds the valid bits down.
  assign busy   = rst;
  assign accept = start && !busy;

  // Cut seconds into whole days and second of day.
  ucal_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .secs      (epoch_seconds),
    .out_valid (split_valid),
    .out       (split)
  );

  // Hour, minute and second from the second of day (six stages).
  ucal_tod u_tod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .sod       (split.sod),
    .out_valid (tod_valid_raw),
    .out       (tod_raw)
  );

  // Weekday, year, month and day from the day count (seven stages).
  ucal_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .days      (split.days),
    .out_valid (date_valid),
    .out       (date)
  );

  // Delay the time-of-day lane one stage to line it up with the date lane.
  always_ff @(posedge clk) begin
    if (rst) begin
      tod_valid <= 1'b0;
    end else begin
      tod_valid <= tod_valid_raw;
    end
  end

  always_ff @(posedge clk) begin
    tod <= tod_raw;
  end

  // Drive the result straight from the last pipeline registers.
  assign done             = date_valid;
  assign second_of_minute = tod.second;
  assign minute_of_hour   = tod.minute;
  assign hour_of_day      = tod.hour;
  assign weekday          = date.weekday;
  assign day_of_month     = date.day;
  assign month_number     = date.month;
  assign full_year        = date.year;

  // A result appears only where a request was taken earlier.
  `UCAL_ASSERT_IMPL(a_latency, done, $past(start && !busy, LATENCY), "result without request")
  // Both lanes must carry the same request.
  `UCAL_ASSERT_ALWAYS(a_lanes_aligned, tod_valid == date_valid, "time and date lanes apart")
  `UCAL_ASSERT_IMPL(a_date_range, done, (month_number >= 4'd1) && (month_number <= 4'd12) && (day_of_month >= 5'd1), "date out of range")
  `UCAL_ASSERT_IMPL(a_time_range, done, (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59) && (second_of_minute <= 6'd59) && (weekday <= 3'd6), "time out of range")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Calendar constants for the predictor.
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned FIRST_YEAR    = 1970;
  localparam int unsigned EPOCH_WDAY    = 4;     // 1970-01-01 was a Thursday
  localparam int unsigned LAST_DAY      = 49710; // last day that starts below 2**32 seconds
  localparam int unsigned MONTH_DAYS [12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Run limits: ~1800 requests with their gaps, plus the pipe fill,
  // sit far below this.
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam int unsigned RANDOM_ITEMS = 1650;

  // One predicted conversion, tagged with the request that caused it.
  typedef struct {
    logic [31:0] secs;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] epoch_seconds;
  logic        done;
  logic [5:0]  second_of_minute;
  logic [5:0]  minute_of_hour;
  logic [4:0]  hour_of_day;
  logic [2:0]  weekday;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [11:0] full_year;

  calendar_t   expected_dates[$];
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned cycle_count = 0;

  unix_seconds_to_calendar dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .epoch_seconds    (epoch_seconds),
    .done             (done),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .weekday          (weekday),
    .day_of_month     (day_of_month),
    .month_number     (month_number),
    .full_year        (full_year)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: end the run if the handshake or the result stream hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, expected_dates.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Gregorian 4/100/400 rule.
  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
    if (mo == 2 && is_leap(yr))
      return 29;
    return MONTH_DAYS[mo - 1];
  endfunction

  // Split a second count into time of day, weekday and date. Strip whole
  // years first, then whole months; what is left is the day within the month.
  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    int unsigned t;
    int unsigned days;
    int unsigned rest;
    int unsigned yr;
    int unsigned mo;
    t      = secs;
    days   = t / SECS_PER_DAY;
    rest   = t % SECS_PER_DAY;
    c.secs   = secs;
    c.second = 6'(rest % SECS_PER_MIN);
    c.minute = 6'((rest % SECS_PER_HOUR) / SECS_PER_MIN);
    c.hour   = 5'(rest / SECS_PER_HOUR);
    c.wday   = 3'((days + EPOCH_WDAY) % 7);
    yr = FIRST_YEAR;
    while (days >= (is_leap(yr) ? 366 : 365)) begin
      days -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    mo = 1;
    while (mo < 12 && days >= month_length(yr, mo)) begin
      days -= month_length(yr, mo);
      mo++;
    end
    c.mday  = 5'(days + 1);
    c.month = 4'(mo);
    c.year  = 12'(yr);
    return c;
  endfunction

  // Draw a second count. Mix plain 32-bit noise with values that sit on
  // day, month and year boundaries and on the last 400 days before the wrap.
  function automatic logic [31:0] random_epoch();
    longint    s;
    longint    d;
    calendar_t c;
    case ($urandom_range(0, 3))
      0: s = $urandom;
      1: begin
        // Hit midnight, the second before it, or the last second of a day.
        s = longint'($urandom_range(0, LAST_DAY)) * SECS_PER_DAY;
        case ($urandom_range(0, 2))
          0: s = s - 1;
          1: s = s;
          default: s = s + SECS_PER_DAY - 1;
        endcase
      end
      2: s = longint'(32'hFFFF_FFFF) - $urandom_range(0, 400 * SECS_PER_DAY);
      default: begin
        // Back up to the first of the month, then land on it or one second
        // before it, so month and year rollovers (and Feb 29) get exercised.
        d = $urandom_range(0, LAST_DAY);
        c = calendar_of(32'(d * SECS_PER_DAY));
        d = d - (c.mday - 1);
        s = d * SECS_PER_DAY - $urandom_range(0, 1);
      end
    endcase
    if (s < 0)
      s = 0;
    if (s > longint'(32'hFFFF_FFFF))
      s = longint'(32'hFFFF_FFFF);
    return s[31:0];
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED)
      $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want, input logic [31:0] secs);
    if (got !== want)
      report_mismatch($sformatf("%s for %0d: got %0d, want %0d", name, secs, got, want));
  endtask

  // Take each strobed result and hold it against the oldest prediction.
  // Results cannot be stalled, so every strobe must find one waiting.
  always @(posedge clk) begin : result_check
    calendar_t want;
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_dates.pop_front();
        compare_field("second_of_minute", second_of_minute, want.second, want.secs);
        compare_field("minute_of_hour", minute_of_hour, want.minute, want.secs);
        compare_field("hour_of_day", hour_of_day, want.hour, want.secs);
        compare_field("weekday", weekday, want.wday, want.secs);
        compare_field("day_of_month", day_of_month, want.mday, want.secs);
        compare_field("month_number", month_number, want.month, want.secs);
        compare_field("full_year", full_year, want.year, want.secs);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Enter and leave at a falling edge. Drop start for the gap, raise it with
  // the new count, and hold it until a rising edge sees busy low. Leave start
  // high on exit so back-to-back requests never toggle it within one step.
  task automatic send_request(input logic [31:0] secs, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    expected_dates.push_back(calendar_of(secs));
    requests_sent++;
    @(negedge clk);
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_dates.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Boundaries: epoch, unit rollovers, leap days, the skipped 2100 leap day,
  // the signed 32-bit wrap and the largest count, plus alternating bits.
  task automatic test_field_extremes();
    logic [31:0] corner_secs [$];
    corner_secs = '{
      32'd0,          // 1970-01-01 00:00:00, Thursday
      32'd59,         // last second of the first minute
      32'd60,         // first minute rollover
      32'd3599,       // last second of the first hour
      32'd3600,
      32'd86399,      // last second of the first day
      32'd86400,
      32'd31449600,   // 1970-12-31
      32'd31535999,   // last second of 1970
      32'd36633600,   // 1971-03-01, no leap day before it
      32'd68169600,   // 1972-02-29
      32'd94694399,   // 1972-12-31 23:59:59
      32'd951782400,  // 2000-02-29, century year that is a leap year
      32'd951868800,  // 2000-03-01
      32'd2147483647, // signed 32-bit wrap point
      32'd4107456000, // 2100-02-28, century year without a leap day
      32'd4107542400, // 2100-03-01
      32'hAAAA_AAAA,
      32'h5555_5555,
      32'hFFFF_FFFF   // last representable second, 2106-02-07
    };
    foreach (corner_secs[i])
      send_request(corner_secs[i], $urandom_range(0, 5));
  endtask

  // Keep start high for a long run of requests, one per cycle while busy is low.
  task automatic test_back_to_back();
    repeat (60)
      send_request(random_epoch(), 0);
  endtask

  // Stop feeding until the pipe is empty, then resume with a burst.
  task automatic test_drain_pause();
    repeat (20)
      send_request(random_epoch(), $urandom_range(0, 5));
    wait_drained();
    repeat (20)
      send_request(random_epoch(), 0);
  endtask

  // Bulk random requests; alternate between gapped stretches and bursts so
  // idle cycles land on every stage of the pipe.
  task automatic test_random_dates();
    bit burst;
    burst = 1'b0;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0)
        burst = ($urandom_range(0, 3) == 0);
      send_request(random_epoch(), burst ? 0 : $urandom_range(0, 5));
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    epoch_seconds   = '0;
    error_count     = 0;
    requests_sent   = 0;
    results_checked = 0;

    // Hold reset, then release it on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_field_extremes();
    test_back_to_back();
    test_drain_pause();
    test_random_dates();

    // Drain, then keep watching past the pipe depth for stray strobes.
    wait_drained();
    repeat (ucal_pkg::LATENCY + 20) @(negedge clk);

    $display("Converted %0d second counts and checked %0d results in %0d cycles.",
             requests_sent, results_checked, cycle_count);
    $display("Covered epoch, unit and month rollovers, leap and century days, the 32-bit top.");
    if (error_count == 0 && expected_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_dates.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> unix_seconds_to_calendar.f
+incdir+src
src/ucal_pkg.sv
src/ucal_split.sv
src/ucal_tod.sv
src/ucal_date.sv
src/unix_seconds_to_calendar.sv
bench/testbench.sv
